/* hdl/assert_macros.svh */
// Assertion helpers for the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHECK_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define CHECK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define CHECK_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define CHECK_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hdl/mtp_pkg.sv */
package mtp_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    // Item kinds carried in the input tuser.
    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic REG_DIMENSION = 1'b0;
    localparam logic REG_MODE      = 1'b1;

    // Operand token passed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              sel2;
        logic [3:0]        k;
        logic signed [31:0] data;
    } t_tok;

    // Coefficient write broadcast to all cells.
    typedef struct packed {
        logic              we_a;
        logic              we_b;
        logic [3:0]        row;
        logic [3:0]        col;
        logic signed [31:0] data;
    } t_load;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED1,
        ST_WAIT1,
        ST_FEED2,
        ST_WAIT2,
        ST_EMIT
    } t_state;

endpackage

/* hdl/mtp_cell.sv */
// One cell of the chain: holds column CELL_IDX of B and row CELL_IDX of A,
// multiplies each passing operand by the matching coefficient and keeps
// an exact running sum, then floors and saturates it at the end of a run.
module mtp_cell #(
    parameter int MAX_DIM   = mtp_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mtp_pkg::FRAC_BITS_DEF,
    parameter int CELL_IDX  = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mtp_pkg::t_tok       i_tok,
    input  mtp_pkg::t_load      i_load,
    output mtp_pkg::t_tok       o_tok,
    output logic signed [31:0]  o_res,
    output logic                o_clip
);
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int ACC_W = 64 + IDX_W + 1;
    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

    logic signed [31:0]      r_b_col [MAX_DIM];
    logic signed [31:0]      r_a_row [MAX_DIM];
    mtp_pkg::t_tok           r_tok;
    logic signed [63:0]      r_prod;
    logic                    r_pv;
    logic                    r_pfirst;
    logic                    r_plast;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_fin;
    logic signed [31:0]      r_res;
    logic                    r_clip;
    logic signed [31:0]      w_coef;
    logic signed [ACC_W-1:0] w_sh;

    assign w_coef = i_tok.sel2 ? r_a_row[i_tok.k[IDX_W-1:0]] : r_b_col[i_tok.k[IDX_W-1:0]];
    assign w_sh   = r_acc >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_load.we_a && (int'(i_load.row) == CELL_IDX)) begin
            r_a_row[i_load.col[IDX_W-1:0]] <= i_load.data;
        end
        if (i_load.we_b && (int'(i_load.col) == CELL_IDX)) begin
            r_b_col[i_load.row[IDX_W-1:0]] <= i_load.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_pv        <= 1'b0;
            r_fin       <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
            r_pv        <= i_tok.valid;
            r_fin       <= r_pv && r_plast;
        end
        r_tok.last <= i_tok.last;
        r_tok.sel2 <= i_tok.sel2;
        r_tok.k    <= i_tok.k;
        r_tok.data <= i_tok.data;
        r_prod     <= 64'($signed(i_tok.data)) * 64'(w_coef);
        r_pfirst   <= (i_tok.k == 4'd0);
        r_plast    <= i_tok.last;
        if (r_pv) begin
            r_acc <= (r_pfirst ? '0 : r_acc) + ACC_W'(r_prod);
        end
        if (r_fin) begin
            if (w_sh > SAT_HI) begin
                r_res  <= 32'(SAT_HI);
                r_clip <= 1'b1;
            end else if (w_sh < SAT_LO) begin
                r_res  <= 32'(SAT_LO);
                r_clip <= 1'b1;
            end else begin
                r_res  <= 32'(w_sh);
                r_clip <= 1'b0;
            end
        end
    end

    assign o_tok  = r_tok;
    assign o_res  = r_res;
    assign o_clip = r_clip;
endmodule

/* hdl/matrix_triple_product.sv */
// Square matrix engine in signed Q(32-FRAC_BITS).FRAC_BITS fixed point. Load items
// (kind 0 for A, 1 for B) each write one element. A start item (kind 2)
// computes A*B (product_mode 0) or A*B*A^T (product_mode 1) on the leading
// n by n corner and then streams all n*n elements in row-major order, with
// tlast on the final one. The work runs on a chain of MAX_DIM cells: cell j
// holds column j of B and row j of A, and operands hop one cell per cycle while
// every cell accumulates one output element of the current row. Each result row
// is fed and then drained through the chain once per pass (one pass in mode 0,
// two in mode 1) and then emitted. No item is accepted while a start is being
// worked on.
`include "assert_macros.svh"
module matrix_triple_product #(
    parameter int MAX_DIM   = mtp_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mtp_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // row_index[2:0], col_index[5:3], element[37:6]
    input  logic [1:0]  i_s_tuser,   // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // out_row[2:0], out_col[5:3], out_value[37:6]
    output logic        o_m_tuser,   // clipped[0]
    output logic        o_m_tlast
);
    localparam int IDX_W    = $clog2(MAX_DIM);
    localparam int N_W      = $clog2(MAX_DIM + 1);
    localparam int WAIT_CYC = MAX_DIM + 4;
    localparam int CNT_W    = $clog2(WAIT_CYC + 1);
    localparam int MEM_D    = 1 << (2 * IDX_W);

    // Configuration registers.
    logic [3:0] r_dim;
    logic       r_pmode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim   <= 4'd4;
            r_pmode <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mtp_pkg::REG_DIMENSION: r_dim   <= i_cfg_data;
                mtp_pkg::REG_MODE:      r_pmode <= i_cfg_data[0];
                default:                r_dim   <= r_dim;
            endcase
        end
    end

    // Input decode.
    logic [2:0]         w_in_row;
    logic [2:0]         w_in_col;
    logic signed [31:0] w_in_elem;
    logic               w_accept;
    logic               w_in_range;
    logic               w_start;
    mtp_pkg::t_load     w_load;
    logic [N_W-1:0]     w_n;

    assign w_in_row   = i_s_tdata[2:0];
    assign w_in_col   = i_s_tdata[5:3];
    assign w_in_elem  = $signed(i_s_tdata[37:6]);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_in_range = (int'(w_in_row) < MAX_DIM) && (int'(w_in_col) < MAX_DIM);
    assign w_start    = w_accept && (i_s_tuser == mtp_pkg::KIND_START);

    always_comb begin
        w_load.we_a = w_accept && w_in_range && (i_s_tuser == mtp_pkg::KIND_LOAD_A);
        w_load.we_b = w_accept && w_in_range && (i_s_tuser == mtp_pkg::KIND_LOAD_B);
        w_load.row  = 4'(w_in_row);
        w_load.col  = 4'(w_in_col);
        w_load.data = w_in_elem;
    end

    // A dimension of zero acts as one, any above the build size as the build size.
    always_comb begin
        if (r_dim == 4'd0) begin
            w_n = N_W'(1);
        end else if (int'(r_dim) > MAX_DIM) begin
            w_n = N_W'(MAX_DIM);
        end else begin
            w_n = N_W'(r_dim);
        end
    end

    // Sequencer state.
    mtp_pkg::t_state r_state;
    mtp_pkg::t_state w_next;
    logic [N_W-1:0]   r_n;
    logic             r_mode;
    logic [IDX_W-1:0] r_i;
    logic [CNT_W-1:0] r_cnt;
    logic             w_cnt_last;
    logic             w_wait_last;
    logic             w_row_last;
    logic             w_feed_en;
    logic             w_feed_src2;
    logic             w_emit_load;
    logic             w_capture;

    assign w_cnt_last  = (r_cnt == CNT_W'(r_n) - CNT_W'(1));
    assign w_wait_last = (r_cnt == CNT_W'(WAIT_CYC - 1));
    assign w_row_last  = (r_i == IDX_W'(r_n - N_W'(1)));

    always_comb begin
        w_next = r_state;
        case (r_state)
            mtp_pkg::ST_IDLE:  if (w_start) w_next = mtp_pkg::ST_FEED1;
            mtp_pkg::ST_FEED1: if (w_cnt_last) w_next = mtp_pkg::ST_WAIT1;
            mtp_pkg::ST_WAIT1: begin
                if (w_wait_last) w_next = r_mode ? mtp_pkg::ST_FEED2 : mtp_pkg::ST_EMIT;
            end
            mtp_pkg::ST_FEED2: if (w_cnt_last) w_next = mtp_pkg::ST_WAIT2;
            mtp_pkg::ST_WAIT2: if (w_wait_last) w_next = mtp_pkg::ST_EMIT;
            mtp_pkg::ST_EMIT: begin
                if (w_emit_load && w_cnt_last) begin
                    w_next = w_row_last ? mtp_pkg::ST_IDLE : mtp_pkg::ST_FEED1;
                end
            end
            default: w_next = mtp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready  = (r_state == mtp_pkg::ST_IDLE);
        w_feed_en   = (r_state == mtp_pkg::ST_FEED1) || (r_state == mtp_pkg::ST_FEED2);
        w_feed_src2 = (r_state == mtp_pkg::ST_FEED2);
        w_emit_load = (r_state == mtp_pkg::ST_EMIT) && (!o_m_tvalid || i_m_tready);
        w_capture   = (r_state == mtp_pkg::ST_WAIT1) && w_wait_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtp_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_i     <= '0;
        end else begin
            r_state <= w_next;
            if (w_start) begin
                r_cnt <= '0;
                r_i   <= '0;
            end else if (r_state != w_next) begin
                r_cnt <= '0;
                if ((r_state == mtp_pkg::ST_EMIT) && (w_next == mtp_pkg::ST_FEED1)) begin
                    r_i <= r_i + IDX_W'(1);
                end
            end else if (r_state != mtp_pkg::ST_IDLE &&
                         (r_state != mtp_pkg::ST_EMIT || w_emit_load)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
        if (w_start) begin
            r_n    <= w_n;
            r_mode <= r_pmode;
        end
    end

    // Store of A, read row by row to feed the first pass.
    logic signed [31:0] r_mem_a [MEM_D];
    logic signed [31:0] r_mem_q;
    logic signed [31:0] r_prow   [MAX_DIM];
    logic               r_pclip  [MAX_DIM];
    logic signed [31:0] r_prow_q;
    logic               r_rowclip;
    logic               r_f_v;
    logic               r_f_last;
    logic               r_f_src2;
    logic [3:0]         r_f_k;

    always_ff @(posedge i_clk) begin
        if (w_load.we_a) begin
            r_mem_a[{w_load.row[IDX_W-1:0], w_load.col[IDX_W-1:0]}] <= w_load.data;
        end
        r_mem_q <= r_mem_a[{r_i, r_cnt[IDX_W-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else begin
            r_f_v <= w_feed_en;
        end
        r_f_last <= w_cnt_last;
        r_f_src2 <= w_feed_src2;
        r_f_k    <= 4'(r_cnt[IDX_W-1:0]);
        r_prow_q <= r_prow[r_cnt[IDX_W-1:0]];
    end

    // Cell chain.
    mtp_pkg::t_tok      w_feed;
    mtp_pkg::t_tok      w_tok  [MAX_DIM];
    logic signed [31:0] w_res  [MAX_DIM];
    logic               w_clip [MAX_DIM];

    always_comb begin
        w_feed.valid = r_f_v;
        w_feed.last  = r_f_last;
        w_feed.sel2  = r_f_src2;
        w_feed.k     = r_f_k;
        w_feed.data  = r_f_src2 ? r_prow_q : r_mem_q;
    end

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        if (g == 0) begin : g_head
            mtp_cell #(
                .MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS), .CELL_IDX(g)
            ) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tok(w_feed), .i_load(w_load),
                .o_tok(w_tok[g]), .o_res(w_res[g]), .o_clip(w_clip[g])
            );
        end else begin : g_body
            mtp_cell #(
                .MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS), .CELL_IDX(g)
            ) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tok(w_tok[g-1]), .i_load(w_load),
                .o_tok(w_tok[g]), .o_res(w_res[g]), .o_clip(w_clip[g])
            );
        end
    end

    // After the first pass, keep the row of A*B and whether any of it clipped.
    logic w_rowclip;

    always_comb begin
        w_rowclip = 1'b0;
        for (int j = 0; j < MAX_DIM; j++) begin
            if ((j < int'(r_n)) && w_clip[j]) w_rowclip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            for (int j = 0; j < MAX_DIM; j++) begin
                r_prow[j]  <= w_res[j];
                r_pclip[j] <= w_clip[j];
            end
            r_rowclip <= w_rowclip;
        end
    end

    // Output register.
    logic [IDX_W-1:0]   w_j;
    logic               r_out_v;
    logic [2:0]         r_out_row;
    logic [2:0]         r_out_col;
    logic signed [31:0] r_out_val;
    logic               r_out_clip;
    logic               r_out_last;

    assign w_j = r_cnt[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_emit_load) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
        if (w_emit_load) begin
            r_out_row  <= 3'(r_i);
            r_out_col  <= 3'(w_j);
            r_out_val  <= r_mode ? w_res[w_j] : r_prow[w_j];
            r_out_clip <= r_mode ? (w_clip[w_j] || r_rowclip) : r_pclip[w_j];
            r_out_last <= w_row_last && w_cnt_last;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {2'b00, r_out_val, r_out_col, r_out_row};
    assign o_m_tuser  = r_out_clip;
    assign o_m_tlast  = r_out_last;

    // The chain must be empty whenever results are read from the cells.
    `CHECK_IMPLY(a_chain_drained, i_clk, i_rst_n, r_state == mtp_pkg::ST_EMIT, !w_feed.valid && !w_tok[MAX_DIM-1].valid, "cell chain busy during emit")
    // A start always launches the first pass.
    `CHECK_NEXT(a_start_feeds, i_clk, i_rst_n, w_start, r_state == mtp_pkg::ST_FEED1 && r_cnt == '0, "start did not begin feeding")
    // The final element of a run sits at the bottom right corner.
    `CHECK_IMPLY(a_last_corner, i_clk, i_rst_n, r_out_v && r_out_last, r_out_row == r_out_col, "last element off the diagonal corner")
endmodule

/* tb/mtp_checker.sv */
`timescale 1ns / 1ps
// Watches the configuration port and both streams of the matrix engine,
// predicts every result element and compares it with what comes out.
module mtp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    input  logic        i_m_tuser,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
        logic               clipped;
        logic               last;
    } t_elem;

    logic signed [31:0] mat_a [8][8];
    logic signed [31:0] mat_b [8][8];
    logic signed [31:0] stage_ab [8][8];
    logic               stage_clip [8][8];
    logic [3:0]         dim_reg;
    logic               mode_reg;
    t_elem              expected_elems [$];

    assign o_pending = expected_elems.size();

    // Floor by FRAC_BITS, then clamp to 32 bits.
    function automatic logic signed [31:0] clamp_sum(input logic signed [79:0] acc,
                                                     output logic sat);
        logic signed [79:0] sh;
        sh  = acc >>> mtp_pkg::FRAC_BITS_DEF;
        sat = 1'b1;
        if (sh > 80'sd2147483647) return 32'sh7FFFFFFF;
        if (sh < -80'sd2147483648) return 32'sh80000000;
        sat = 1'b0;
        return sh[31:0];
    endfunction

    task automatic predict_run();
        int n;
        logic signed [79:0] acc, x, y;
        logic sat, row_clip;
        t_elem e;
        n = (dim_reg == 0) ? 1 : (dim_reg > 8) ? 8 : dim_reg;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = 0;
                for (int k = 0; k < n; k++) begin
                    x = mat_a[i][k];
                    y = mat_b[k][j];
                    acc += x * y;
                end
                stage_ab[i][j] = clamp_sum(acc, sat);
                stage_clip[i][j] = sat;
            end
        end
        for (int i = 0; i < n; i++) begin
            row_clip = 1'b0;
            for (int j = 0; j < n; j++) row_clip |= stage_clip[i][j];
            for (int j = 0; j < n; j++) begin
                e.row  = i[2:0];
                e.col  = j[2:0];
                e.last = (i == n - 1) && (j == n - 1);
                if (!mode_reg) begin
                    e.value   = stage_ab[i][j];
                    e.clipped = stage_clip[i][j];
                end else begin
                    // Row i of the first stage against row j of A.
                    acc = 0;
                    for (int k = 0; k < n; k++) begin
                        x = stage_ab[i][k];
                        y = mat_a[j][k];
                        acc += x * y;
                    end
                    e.value   = clamp_sum(acc, sat);
                    e.clipped = sat | row_clip;
                end
                expected_elems.push_back(e);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_elem got, want;
        if (!i_rst_n) begin
            dim_reg  <= 4'd4;
            mode_reg <= 1'b1;
            o_fail_count = 0;
            expected_elems.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == mtp_pkg::REG_DIMENSION) dim_reg <= i_cfg_data;
                else mode_reg <= i_cfg_data[0];
            end
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    mtp_pkg::KIND_LOAD_A:
                        mat_a[i_s_tdata[2:0]][i_s_tdata[5:3]] = i_s_tdata[37:6];
                    mtp_pkg::KIND_LOAD_B:
                        mat_b[i_s_tdata[2:0]][i_s_tdata[5:3]] = i_s_tdata[37:6];
                    mtp_pkg::KIND_START:  predict_run();
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[2:0], i_m_tdata[5:3], i_m_tdata[37:6], i_m_tuser, i_m_tlast};
                if (expected_elems.size() == 0) begin
                    $error("result element with nothing expected: row %0d col %0d",
                           got.row, got.col);
                    o_fail_count++;
                end else begin
                    want = expected_elems.pop_front();
                    if (got.row !== want.row) begin
                        $error("out_row: expected %0d, got %0d", want.row, got.row);
                        o_fail_count++;
                    end
                    if (got.col !== want.col) begin
                        $error("out_col: expected %0d, got %0d", want.col, got.col);
                        o_fail_count++;
                    end
                    if (got.value !== want.value) begin
                        $error("out_value: expected %0d, got %0d", want.value, got.value);
                        o_fail_count++;
                    end
                    if (got.clipped !== want.clipped) begin
                        $error("clipped: expected %0b, got %0b", want.clipped, got.clipped);
                        o_fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

/* tb/matrix_triple_product_tb.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the matrix engine. The checker beside the block
// does all prediction; this module only feeds items and configuration, stalls
// the output and reports the outcome.
module matrix_triple_product_tb;

    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [3:0]  i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    int fail_count;
    int pending_elems;
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;

    matrix_triple_product uut (.*);

    mtp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser), .i_m_tlast(o_m_tlast),
        .o_fail_count(fail_count), .o_pending(pending_elems)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The output side stalls at random with the current idle percentage.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a hung block must not hang the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[matrix_triple_product] ERROR");
            $finish;
        end
    end

    // Mostly small values so the products stay in range, with the extremes
    // and fully random words mixed in to force saturation now and then.
    function automatic logic [31:0] pick_element();
        case ($urandom_range(9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2, 3: return $urandom;
            default: return $urandom_range(0, 1 << 19) - (1 << 18);
        endcase
    endfunction

    // Offers one item, with random idle cycles ahead of it, and returns once
    // it has been taken. The ready is checked on the falling edge so that the
    // handshake is certain at the next rising edge.
    task automatic send_item(input logic [1:0] kind, input logic [2:0] row,
                             input logic [2:0] col, input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {2'b00, value, col, row};
        @(negedge i_clk);
        while (!o_s_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Waits until every expected element is out, then lets the engine settle.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_elems != 0) @(negedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Register writes happen only once the block has gone quiet.
    task automatic set_config(input logic [3:0] dim, input logic mode);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= mtp_pkg::REG_DIMENSION;
        i_cfg_data <= dim;
        @(posedge i_clk);
        i_cfg_idx  <= mtp_pkg::REG_MODE;
        i_cfg_data <= {3'b000, mode};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // A run of random loads with a start now and then, some items of the
    // unused kind as noise, and always a closing start.
    task automatic random_block(input int count);
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(19);
            if (roll < 2) begin
                send_item(mtp_pkg::KIND_START, 3'($urandom), 3'($urandom), $urandom);
            end else if (roll == 2) begin
                send_item(mtp_pkg::KIND_UNUSED, 3'($urandom), 3'($urandom), $urandom);
            end else begin
                send_item(roll[0] ? mtp_pkg::KIND_LOAD_B : mtp_pkg::KIND_LOAD_A,
                          3'($urandom), 3'($urandom), pick_element());
            end
        end
        send_item(mtp_pkg::KIND_START, 3'd0, 3'd0, 32'd0);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = 1'b0;
        i_cfg_data    = 4'd0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = mtp_pkg::KIND_LOAD_A;
        send_idle_pct = 35;
        recv_idle_pct = 77;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every element of both stores gets written first, so no start ever
        // reads an entry that holds nothing.
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
                send_item(mtp_pkg::KIND_LOAD_A, 3'(r), 3'(c), pick_element());
                send_item(mtp_pkg::KIND_LOAD_B, 3'(r), 3'(c), pick_element());
            end
        end
        // Start under the reset settings.
        send_item(mtp_pkg::KIND_START, 3'd0, 3'd0, 32'd0);

        // One by one matrices with extreme values, both modes; a dimension of
        // zero must act as one.
        set_config(4'd0, 1'b0);
        send_item(mtp_pkg::KIND_LOAD_A, 3'd0, 3'd0, 32'h7FFFFFFF);
        send_item(mtp_pkg::KIND_LOAD_B, 3'd0, 3'd0, 32'h80000000);
        send_item(mtp_pkg::KIND_START, 3'd7, 3'd7, 32'hFFFFFFFF);
        set_config(4'd1, 1'b1);
        send_item(mtp_pkg::KIND_START, 3'd0, 3'd0, 32'd0);
        send_item(mtp_pkg::KIND_LOAD_B, 3'd0, 3'd0, 32'hFFFFFFFF);
        send_item(mtp_pkg::KIND_UNUSED, 3'd0, 3'd0, 32'h12345678);
        send_item(mtp_pkg::KIND_START, 3'd0, 3'd0, 32'd0);
        // A dimension above the maximum acts as the maximum; full-scale
        // entries make both stages saturate.
        set_config(4'd15, 1'b1);
        send_item(mtp_pkg::KIND_LOAD_A, 3'd7, 3'd7, 32'h80000000);
        send_item(mtp_pkg::KIND_LOAD_B, 3'd7, 3'd7, 32'h80000000);
        send_item(mtp_pkg::KIND_LOAD_A, 3'd7, 3'd0, 32'h7FFFFFFF);
        send_item(mtp_pkg::KIND_START, 3'd0, 3'd0, 32'd0);
        set_config(4'd8, 1'b0);
        send_item(mtp_pkg::KIND_LOAD_A, 3'd0, 3'd0, 32'h00000000);
        send_item(mtp_pkg::KIND_START, 3'd0, 3'd0, 32'd0);

        set_config(4'd2, 1'b1);
        random_block(6);
        set_config(4'd8, 1'b0);
        random_block(6);

        send_idle_pct = 77;
        recv_idle_pct = 35;
        set_config(4'd3, 1'b0);
        random_block(6);
        set_config(4'd5, 1'b1);
        random_block(6);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(4'd8, 1'b1);
        random_block(6);
        set_config(4'd1, 1'b0);
        random_block(6);

        wait_drained();
        if (fail_count == 0) begin
            $display("[matrix_triple_product] OK");
        end else begin
            $display("[matrix_triple_product] ERROR");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hdl
hdl/mtp_pkg.sv
hdl/mtp_cell.sv
hdl/matrix_triple_product.sv
tb/mtp_checker.sv
tb/matrix_triple_product_tb.sv
